// ===== rtl/cfq_pkg.sv =====
package cfq_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Capacity register and entry count widths (fixed by the register map)
  localparam int CAP_W = 5;
  localparam int CNT_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes
  localparam logic [2:0] OP_ENQ    = 3'd0;
  localparam logic [2:0] OP_DEQ    = 3'd1;
  localparam logic [2:0] OP_PEEK_F = 3'd2;
  localparam logic [2:0] OP_PEEK_R = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;

  // Status codes
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_REJECTED = 1'b1;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic             enq;    // load the first free cell
    logic             deq;    // shift the whole chain one place towards the head
    logic [CNT_W-1:0] count;  // entries held before this request
  } cell_ctrl_t;

endpackage

// ===== rtl/circular_fifo_queue.sv =====
// The result is registered and becomes valid in the cycle after the request is accepted.
// Throughput: one request per cycle; a request is taken whenever the result
// register is empty or is being drained in the same cycle.
// Storage is a shifting chain of DEPTH cells, the oldest element in cell 0.
// Reset (synchronous): queue empty, capacity 16, no result pending, no request
// taken while reset is high.
module circular_fifo_queue #(
  parameter int DEPTH      = cfq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                operation,
  input  logic [DATA_WIDTH-1:0]     value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      status,
  output logic [DATA_WIDTH-1:0]     data,
  output logic [cfq_pkg::CNT_W-1:0] count,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam logic [cfq_pkg::CAP_W-1:0] DepthClamp =
    cfq_pkg::CAP_W'((DEPTH > 31) ? 31 : DEPTH);

  logic [cfq_pkg::CAP_W-1:0] capacity;
  logic [cfq_pkg::CAP_W-1:0] cap_eff;
  logic [cfq_pkg::CNT_W-1:0] entries;
  logic [cfq_pkg::CNT_W-1:0] entries_next;
  logic [DATA_WIDTH-1:0]     rear;
  logic [DATA_WIDTH-1:0]     cell_data [DEPTH];
  logic                      in_fire;
  logic                      full;
  logic                      empty;
  logic                      res_status;
  logic [DATA_WIDTH-1:0]     res_data;
  logic                      do_enq;
  logic                      do_deq;
  logic                      cfg_wr;
  cfq_pkg::cell_ctrl_t       ctrl;

  // Handshake; nothing is taken while in reset
  assign in_fire  = in_valid && in_ready;
  assign in_ready = !rst && (!out_valid || out_ready);

  // Effective capacity: zero acts as one, clamp at the storage depth
  always_comb begin
    if (capacity == '0) begin
      cap_eff = cfq_pkg::CAP_W'(1);
    end else if (32'(capacity) > DEPTH) begin
      cap_eff = DepthClamp;
    end else begin
      cap_eff = capacity;
    end
  end

  assign full  = (entries >= cap_eff);
  assign empty = (entries == '0);

  // Decode the request and build its result
  always_comb begin
    res_status = cfq_pkg::ST_REJECTED;
    res_data   = '0;
    do_enq     = 1'b0;
    do_deq     = 1'b0;
    case (operation)
      cfq_pkg::OP_ENQ: begin
        if (!full) begin
          res_status = cfq_pkg::ST_OK;
          do_enq     = 1'b1;
        end
      end
      cfq_pkg::OP_DEQ: begin
        if (!empty) begin
          res_status = cfq_pkg::ST_OK;
          res_data   = cell_data[0];
          do_deq     = 1'b1;
        end
      end
      cfq_pkg::OP_PEEK_F: begin
        if (!empty) begin
          res_status = cfq_pkg::ST_OK;
          res_data   = cell_data[0];
        end
      end
      cfq_pkg::OP_PEEK_R: begin
        if (!empty) begin
          res_status = cfq_pkg::ST_OK;
          res_data   = rear;
        end
      end
      cfq_pkg::OP_COUNT: begin
        res_status = cfq_pkg::ST_OK;
      end
      default: begin
        res_status = cfq_pkg::ST_REJECTED;
      end
    endcase
  end

  // Entry count after the request
  always_comb begin
    entries_next = entries;
    if (do_enq) begin
      entries_next = entries + cfq_pkg::CNT_W'(1);
    end else if (do_deq) begin
      entries_next = entries - cfq_pkg::CNT_W'(1);
    end
  end

  // Cell chain control, only on an accepted request
  assign ctrl.enq   = in_fire && do_enq;
  assign ctrl.deq   = in_fire && do_deq;
  assign ctrl.count = entries;

  // Chain of storage cells; the last one shifts in don't-care data
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] nxt;
    if (i == DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cell_data[i+1];
    end
    cfq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .value     (value),
      .next_data (nxt),
      .data      (cell_data[i])
    );
  end

  // Rear copy: last element enqueued
  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      rear <= value;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= '0;
    end else if (in_fire) begin
      entries <= entries_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status <= res_status;
      data   <= res_data;
      count  <= entries_next;
    end
  end

  // Configuration: capacity taken only while the queue is empty
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= cfq_pkg::CAP_RESET;
    end else if (cfg_wr && (paddr[2] == 1'b0) && empty) begin
      capacity <= pwdata[cfq_pkg::CAP_W-1:0];
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entries <= cap_eff)
    else $error("entry count above effective capacity");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && operation == cfq_pkg::OP_ENQ && !full)
      |=> (entries == $past(entries) + cfq_pkg::CNT_W'(1)))
    else $error("accepted enqueue did not raise the count");

  a_deq_data: assert property (@(posedge clk) disable iff (rst)
    (in_fire && operation == cfq_pkg::OP_DEQ && !empty)
      |=> (status == cfq_pkg::ST_OK && data == $past(cell_data[0])))
    else $error("dequeue result does not match the head cell");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    $past(in_fire) |-> (count == entries))
    else $error("result count differs from entry count");

endmodule

// ===== rtl/cfq_cell.sv =====
module cfq_cell #(
  parameter int DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  cfq_pkg::cell_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0]  value,
  input  logic [DATA_WIDTH-1:0]  next_data,
  output logic [DATA_WIDTH-1:0]  data
);

  // This cell is the first free one when the count equals its position
  logic is_tail_slot;
  assign is_tail_slot = (32'(ctrl.count) == INDEX);

  // Shift from the neighbour on dequeue, capture the new element on enqueue
  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      data <= next_data;
    end else if (ctrl.enq && is_tail_slot) begin
      data <= value;
    end
  end

endmodule
